/* rtl/psaa_pkg.sv */
// Shared types and constants for the polar scan area accumulator.
// Holds the front-to-back command format and the fixed-point constants of the sine and area path.
// No dependencies.
package psaa_pkg;

  localparam int ANGLE_W = 15;
  localparam int DIST_W  = 16;
  localparam int COUNT_W = 10;
  localparam int AREA_W  = 41;
  localparam int FOLD_W  = 13;
  localparam int X_W     = 31;
  localparam int ACC_W   = 64;

  localparam int QUEUE_DEPTH = 2;

  // One full turn, half turn and quarter turn in 1/64 degree
  localparam logic signed [16:0] ANGLE_FULL    = 17'sd23040;
  localparam logic [14:0]        ANGLE_HALF    = 15'd11520;
  localparam logic [13:0]        ANGLE_QUARTER = 14'd5760;

  // x = fold * pi/11520 in Q30 = fold * X_COEF_INT + (fold * X_COEF_REM + X_RND) / 11520
  localparam logic [18:0] X_COEF_INT  = 19'd292817;
  localparam logic [12:0] X_COEF_REM  = 13'd7586;
  localparam logic [12:0] X_RND       = 13'd5760;
  // Divide by 45 after the shift by 8: multiply and drop 24 bits, exact over 18 bits
  localparam logic [18:0] DIV45_RECIP = 19'd372828;
  localparam int          DIV45_SHIFT = 24;

  // Half a square quarter-millimetre in square inches, Q48
  localparam logic [33:0] AREA_GAIN = 34'd13633916917;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd1023;

  localparam logic [AREA_W-1:0] AREA_POS_LIMIT = 41'h0FFFFFFFFFF;
  localparam logic [AREA_W-1:0] AREA_NEG_LIMIT = 41'h10000000000;
  localparam logic [ACC_W-1:0]  ACC_POS_LIMIT  = 64'h7FFFFFFFFFFFFFFF;
  localparam logic [ACC_W-1:0]  ACC_NEG_LIMIT  = 64'h8000000000000000;

  typedef struct packed {
    logic               add;
    logic               neg;
    logic [FOLD_W-1:0]  fold;
    logic [DIST_W-1:0]  d_prev;
    logic [DIST_W-1:0]  d_cur;
    logic               last;
    logic [COUNT_W-1:0] count;
  } cmd_t;

  // Reciprocal of the Taylor divisor (2k)(2k+1), exact floor for 32-bit dividends
  function automatic logic [32:0] div_recip(input logic [2:0] idx);
    logic [32:0] r;
    case (idx)
      3'd1:    r = 33'd5726623062;
      3'd2:    r = 33'd6871947674;
      3'd3:    r = 33'd6544712071;
      3'd4:    r = 33'd7635497416;
      3'd5:    r = 33'd4997780127;
      3'd6:    r = 33'd7048151461;
      3'd7:    r = 33'd5235769657;
      default: r = 33'd0;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] div_shift(input logic [2:0] idx);
    logic [5:0] s;
    case (idx)
      3'd1:    s = 6'd35;
      3'd2:    s = 6'd37;
      3'd3:    s = 6'd38;
      3'd4:    s = 6'd39;
      3'd5:    s = 6'd39;
      3'd6:    s = 6'd40;
      3'd7:    s = 6'd40;
      default: s = 6'd0;
    endcase
    return s;
  endfunction

endpackage

/* rtl/psaa_front.sv */
// Front end: accepts scanner samples, tracks the previous sample and the scan count,
// and turns each sample into a command for the back end. Uses psaa_pkg.
module psaa_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 sample_valid,
  input  logic [7:0]                           angle_high,
  input  logic [7:0]                           angle_low,
  input  logic [7:0]                           distance_high,
  input  logic [7:0]                           distance_low,
  input  logic                                 last_sample,
  input  logic                                 full,
  output logic                                 push,
  output psaa_pkg::cmd_t                       cmd
);
  import psaa_pkg::*;

  logic [ANGLE_W-1:0]  prev_angle;
  logic [DIST_W-1:0]   prev_dist;
  logic                have_prev;
  logic [COUNT_W-1:0]  count;

  logic [ANGLE_W-1:0]  angle;
  logic [DIST_W-1:0]   distance;
  logic signed [16:0]  diff;
  logic signed [16:0]  d1;
  logic signed [16:0]  d2;
  logic [14:0]         d3;
  logic [13:0]         m1;
  logic                neg;
  logic [FOLD_W-1:0]   fold;
  logic                keep_prev;
  logic [COUNT_W-1:0]  count_inc;

  always_comb begin
    angle    = {angle_high, angle_low[7:1]};
    distance = {distance_high, distance_low};
    diff  = $signed({2'b00, angle}) - $signed({2'b00, prev_angle});
    // Wrap the difference into one turn
    d1 = diff[16] ? diff + ANGLE_FULL : diff;
    d2 = d1[16] ? d1 + ANGLE_FULL : d1;
    d3 = (d2 >= ANGLE_FULL) ? 15'(d2 - ANGLE_FULL) : d2[14:0];
    // Fold into the first quadrant and keep the sign apart
    neg  = (d3 >= ANGLE_HALF);
    m1   = neg ? 14'(d3 - ANGLE_HALF) : 14'(d3);
    fold = (m1 > ANGLE_QUARTER) ? 13'(14'(ANGLE_HALF) - m1) : m1[12:0];
    // A dropout after a valid return: hold the previous distance
    keep_prev = have_prev && (prev_dist != '0) && (distance == '0);
    count_inc = (count != COUNT_MAX) ? count + 10'd1 : count;
  end

  assign push = sample_valid && !full;

  always_comb begin
    cmd.add    = have_prev && (prev_dist != '0) && (distance != '0);
    cmd.neg    = neg;
    cmd.fold   = fold;
    cmd.d_prev = prev_dist;
    cmd.d_cur  = distance;
    cmd.last   = last_sample;
    cmd.count  = count_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_angle <= '0;
      prev_dist  <= '0;
      have_prev  <= 1'b0;
      count      <= '0;
    end else if (push) begin
      if (last_sample) begin
        prev_angle <= '0;
        prev_dist  <= '0;
        have_prev  <= 1'b0;
        count      <= '0;
      end else begin
        prev_angle <= angle;
        prev_dist  <= keep_prev ? prev_dist : distance;
        have_prev  <= 1'b1;
        count      <= count_inc;
      end
    end
  end

endmodule

/* rtl/psaa_queue.sv */
// Short command queue between the front and back ends of the area accumulator.
// Depth and entry type come from psaa_pkg.
module psaa_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  psaa_pkg::cmd_t wr_data,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output psaa_pkg::cmd_t rd_data
);
  import psaa_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full    = (fill == CNT_W'(QUEUE_DEPTH));
  assign empty   = (fill == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

/* rtl/psaa_back.sv */
// Back end: computes the sine by a stepped Taylor series, scales the triangle area,
// accumulates with saturation and holds the scan result. Uses psaa_pkg.
module psaa_back #(
  parameter int SINE_FRAC_BITS = 16,
  parameter int AREA_FRAC_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 empty,
  input  psaa_pkg::cmd_t                       head,
  output logic                                 pop,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic signed [psaa_pkg::AREA_W-1:0]   area,
  output logic [psaa_pkg::COUNT_W-1:0]         sample_count
);
  import psaa_pkg::*;

  localparam int SW         = SINE_FRAC_BITS + 1;
  localparam int P2W        = 32 + SW;
  localparam int PW         = P2W + 34;
  localparam int AREA_SHIFT = 48 + SINE_FRAC_BITS - AREA_FRAC_BITS;
  localparam logic [31:0] SINE_RND = 32'(1) << (29 - SINE_FRAC_BITS);
  localparam logic [PW:0] AREA_RND = (PW + 1)'(1) << (AREA_SHIFT - 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_ANG1 = 4'd1;
  localparam logic [3:0] ST_ANG2 = 4'd2;
  localparam logic [3:0] ST_ANG3 = 4'd3;
  localparam logic [3:0] ST_T1   = 4'd4;
  localparam logic [3:0] ST_T2   = 4'd5;
  localparam logic [3:0] ST_T3   = 4'd6;
  localparam logic [3:0] ST_T4   = 4'd7;
  localparam logic [3:0] ST_SIN  = 4'd8;
  localparam logic [3:0] ST_P2   = 4'd9;
  localparam logic [3:0] ST_P3A  = 4'd10;
  localparam logic [3:0] ST_P3B  = 4'd11;
  localparam logic [3:0] ST_MAG  = 4'd12;
  localparam logic [3:0] ST_ACC  = 4'd13;
  localparam logic [3:0] ST_DONE = 4'd14;

  logic [3:0]               state;
  logic [2:0]               k;
  cmd_t                     cur;
  logic [X_W-1:0]           mq;
  logic [25:0]              nq;
  logic [12:0]              q;
  logic [X_W-1:0]           x;
  logic [X_W-1:0]           term;
  logic [31:0]              t1;
  logic [31:0]              t2;
  logic [64:0]              pr;
  logic signed [33:0]       sum;
  logic [SW-1:0]            s;
  logic [31:0]              p1;
  logic [P2W-1:0]           p2;
  logic [PW-1:0]            p3;
  logic [ACC_W-1:0]         mag;
  logic signed [ACC_W-1:0]  acc;

  logic [31:0]              mq_full;
  logic [25:0]              nq_full;
  logic [36:0]              qv_full;
  logic [X_W-1:0]           x_new;
  logic [61:0]              prod_tx;
  logic [62:0]              prod_t1x;
  logic [64:0]              prod_r;
  logic [X_W-1:0]           term_new;
  logic signed [33:0]       sum_next;
  logic [30:0]              sum_clamp;
  logic [SW-1:0]            s_new;
  logic [31:0]              p1_full;
  logic [P2W-1:0]           p2_full;
  logic [16:0]              gain_part;
  logic [PW-1:0]            p3_part;
  logic [PW:0]              rsum;
  logic signed [ACC_W-1:0]  tval;
  logic [ACC_W:0]           acc_sum;
  logic signed [ACC_W-1:0]  acc_next;
  logic [AREA_W-1:0]        area_sat;
  logic                     out_free;

  always_comb begin
    mq_full  = 32'(cur.fold) * 32'(X_COEF_INT);
    nq_full  = 26'(cur.fold) * 26'(X_COEF_REM) + 26'(X_RND);
    p1_full  = 32'(cur.d_prev) * 32'(cur.d_cur);
    qv_full  = 37'(nq[25:8]) * 37'(DIV45_RECIP);
    x_new    = mq + 31'(q);
    prod_tx  = 62'(term) * 62'(x);
    prod_t1x = 63'(t1) * 63'(x);
    prod_r   = 65'(t2) * 65'(div_recip(k));
    term_new = 31'(pr >> div_shift(k));
    // Odd terms subtract, even terms add
    sum_next = k[0] ? sum - $signed({3'b000, term_new}) : sum + $signed({3'b000, term_new});
    if (sum[33]) begin
      sum_clamp = '0;
    end else if (sum > 34'sd1073741824) begin
      sum_clamp = 31'h40000000;
    end else begin
      sum_clamp = sum[30:0];
    end
    s_new     = SW'((32'(sum_clamp) + SINE_RND) >> (30 - SINE_FRAC_BITS));
    p2_full   = P2W'(p1) * P2W'(s);
    gain_part = (state == ST_P3A) ? AREA_GAIN[16:0] : AREA_GAIN[33:17];
    p3_part   = PW'(p2) * PW'(gain_part);
    rsum      = (PW + 1)'(p3) + AREA_RND;
    tval      = cur.neg ? -$signed(mag) : $signed(mag);
    acc_sum   = {acc[ACC_W-1], acc} + {tval[ACC_W-1], tval};
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_next = acc_sum[ACC_W] ? $signed(ACC_NEG_LIMIT) : $signed(ACC_POS_LIMIT);
    end else begin
      acc_next = $signed(acc_sum[ACC_W-1:0]);
    end
    if ((&acc[ACC_W-1:AREA_W-1]) || !(|acc[ACC_W-1:AREA_W-1])) begin
      area_sat = acc[AREA_W-1:0];
    end else begin
      area_sat = acc[ACC_W-1] ? AREA_NEG_LIMIT : AREA_POS_LIMIT;
    end
    out_free = !result_valid || !result_stall;
  end

  assign pop = (state == ST_IDLE) && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      k            <= 3'd1;
      acc          <= '0;
      result_valid <= 1'b0;
    end else begin
      if ((state == ST_DONE) && cur.last && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!empty) begin
            state <= head.add ? ST_ANG1 : ST_DONE;
          end
        end
        ST_ANG1: state <= ST_ANG2;
        ST_ANG2: state <= ST_ANG3;
        ST_ANG3: begin
          k     <= 3'd1;
          state <= ST_T1;
        end
        ST_T1:   state <= ST_T2;
        ST_T2:   state <= ST_T3;
        ST_T3:   state <= ST_T4;
        ST_T4: begin
          if (k == 3'd7) begin
            state <= ST_SIN;
          end else begin
            k     <= k + 3'd1;
            state <= ST_T1;
          end
        end
        ST_SIN:  state <= ST_P2;
        ST_P2:   state <= ST_P3A;
        ST_P3A:  state <= ST_P3B;
        ST_P3B:  state <= ST_MAG;
        ST_MAG:  state <= ST_ACC;
        ST_ACC: begin
          acc   <= acc_next;
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!cur.last) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            // Emit the scan and start the next one from zero
            acc          <= '0;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: cur <= head;
      ST_ANG1: begin
        mq <= mq_full[X_W-1:0];
        nq <= nq_full;
        p1 <= p1_full;
      end
      ST_ANG2: q <= qv_full[36:DIV45_SHIFT];
      ST_ANG3: begin
        x    <= x_new;
        term <= x_new;
        sum  <= $signed({3'b000, x_new});
      end
      ST_T1:   t1 <= prod_tx[61:30];
      ST_T2:   t2 <= prod_t1x[61:30];
      ST_T3:   pr <= prod_r;
      ST_T4: begin
        term <= term_new;
        sum  <= sum_next;
      end
      ST_SIN:  s  <= s_new;
      ST_P2:   p2 <= p2_full;
      ST_P3A:  p3 <= p3_part;
      ST_P3B:  p3 <= p3 + (p3_part << 17);
      ST_MAG:  mag <= 64'(rsum >> AREA_SHIFT);
      ST_DONE: begin
        if (cur.last && out_free) begin
          area         <= $signed(area_sat);
          sample_count <= cur.count;
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/polar_scan_area_accumulator.sv */
// Polar scan area accumulator: sums the triangle fan of a range scan, one sample per item.
// A sample that adds area runs the angle states, the seven Taylor terms of the sine
// (states T1 to T4 each) and the area states; a sample that adds none goes idle to done.
// Samples are accepted while the two-entry command queue has room.
// The result leaves via an output register; rst (synchronous) clears the control state.
module polar_scan_area_accumulator #(
  parameter int SINE_FRAC_BITS = 16,
  parameter int AREA_FRAC_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               sample_valid,
  output logic                               sample_stall,
  input  logic [7:0]                         angle_high,
  input  logic [7:0]                         angle_low,
  input  logic [7:0]                         distance_high,
  input  logic [7:0]                         distance_low,
  input  logic                               last_sample,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic signed [psaa_pkg::AREA_W-1:0] area,
  output logic [psaa_pkg::COUNT_W-1:0]       sample_count
);
  import psaa_pkg::*;

  logic push;
  logic pop;
  logic full;
  logic empty;
  cmd_t wr_cmd;
  cmd_t rd_cmd;

  assign sample_stall = full;

  psaa_front u_front (
    .clk           (clk),
    .rst           (rst),
    .sample_valid  (sample_valid),
    .angle_high    (angle_high),
    .angle_low     (angle_low),
    .distance_high (distance_high),
    .distance_low  (distance_low),
    .last_sample   (last_sample),
    .full          (full),
    .push          (push),
    .cmd           (wr_cmd)
  );

  psaa_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_cmd),
    .pop     (pop),
    .full    (full),
    .empty   (empty),
    .rd_data (rd_cmd)
  );

  psaa_back #(
    .SINE_FRAC_BITS (SINE_FRAC_BITS),
    .AREA_FRAC_BITS (AREA_FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (empty),
    .head         (rd_cmd),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .area         (area),
    .sample_count (sample_count)
  );

endmodule

/* rtl/psaa_checker.sv */
// Port-level checks for the polar scan area accumulator, bound to the top level.
// Depends on psaa_pkg for field widths.
module psaa_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               result_valid,
  input logic                               result_stall,
  input logic signed [psaa_pkg::AREA_W-1:0] area,
  input logic [psaa_pkg::COUNT_W-1:0]       sample_count
);

  // Hold a stalled result
  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(area) && $stable(sample_count))
    else $error("result payload changed while stalled");

  // Reset drops any pending result
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // Every scan result covers at least its last sample
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> sample_count != '0)
    else $error("result with zero sample count");

endmodule

bind polar_scan_area_accumulator psaa_checker u_psaa_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .area         (area),
  .sample_count (sample_count)
);

/* bench/psaa_scan_checker.sv */
`timescale 1ns / 1ps
// Scan checker for polar_scan_area_accumulator: watches both channels, predicts the scan area.
// Uses psaa_pkg for the output widths only; the prediction is computed here from first principles.
module psaa_scan_checker #(
  parameter int SINE_FRAC_BITS = 16,
  parameter int AREA_FRAC_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               sample_valid,
  input  logic                               sample_stall,
  input  logic [7:0]                         angle_high,
  input  logic [7:0]                         angle_low,
  input  logic [7:0]                         distance_high,
  input  logic [7:0]                         distance_low,
  input  logic                               last_sample,
  input  logic                               result_valid,
  input  logic                               result_stall,
  input  logic signed [psaa_pkg::AREA_W-1:0] area,
  input  logic [psaa_pkg::COUNT_W-1:0]       sample_count,
  output int                                 mismatch_count,
  output int                                 totals_waiting
);

  // Angles in 1/64 degree
  localparam int FULL_TURN    = 23040;
  localparam int HALF_TURN    = 11520;
  localparam int QUARTER_TURN = 5760;
  localparam bit [63:0] PI_Q30 = 64'd3373259426;
  // Half a square quarter-millimetre in square inches, Q48
  localparam bit [63:0] TRI_GAIN_Q48 =
    ((64'd15499969 << 33) + 64'd9765625 / 2) / 64'd9765625;
  localparam int TRI_SHIFT = 48 + SINE_FRAC_BITS - AREA_FRAC_BITS;
  localparam bit [9:0] COUNT_CAP = 10'd1023;
  localparam longint ACC_TOP    = 64'sh7FFFFFFFFFFFFFFF;
  localparam longint ACC_BOTTOM = -ACC_TOP - 1;
  localparam longint AREA_TOP    = 64'sd1099511627775;
  localparam longint AREA_BOTTOM = -64'sd1099511627776;

  typedef struct {
    bit [psaa_pkg::AREA_W-1:0]  area;
    bit [psaa_pkg::COUNT_W-1:0] count;
  } scan_total_t;

  scan_total_t scan_totals_q[$];

  bit [14:0] prev_angle;
  bit [15:0] prev_dist;
  bit        have_prev;
  longint    running_area;
  bit [9:0]  samples_in_scan;

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic clear_scan();
    prev_angle      = '0;
    prev_dist       = '0;
    have_prev       = 1'b0;
    running_area    = 0;
    samples_in_scan = '0;
  endtask

  // |sin(diff)| in Q SINE_FRAC_BITS from a Taylor series in Q30
  function automatic bit [63:0] sine_mag(input int diff, output bit neg);
    int        m;
    bit [63:0] x;
    bit [63:0] term;
    longint    sum;
    m = diff % FULL_TURN;
    if (m < 0) m += FULL_TURN;
    neg = 1'b0;
    if (m >= HALF_TURN) begin
      neg = 1'b1;
      m -= HALF_TURN;
    end
    if (m > QUARTER_TURN) m = HALF_TURN - m;
    x = (64'(m) * PI_Q30 + 64'(HALF_TURN / 2)) / 64'(HALF_TURN);
    term = x;
    sum = longint'(x);
    for (int k = 1; k <= 7; k++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
    return (64'(sum) + (64'd1 << (29 - SINE_FRAC_BITS))) >> (30 - SINE_FRAC_BITS);
  endfunction

  task automatic add_triangle(input bit [15:0] d_prev, input bit [15:0] d_cur, input int diff);
    bit         neg;
    bit [63:0]  s;
    bit [63:0]  lin;
    bit [127:0] prod;
    longint     t;
    s = sine_mag(diff, neg);
    lin = 64'(d_prev) * 64'(d_cur) * s;
    prod = 128'(lin) * 128'(TRI_GAIN_Q48);
    prod = (prod + (128'd1 << (TRI_SHIFT - 1))) >> TRI_SHIFT;
    t = longint'(prod[63:0]);
    if (neg) t = -t;
    if (t > 0 && running_area > ACC_TOP - t) running_area = ACC_TOP;
    else if (t < 0 && running_area < ACC_BOTTOM - t) running_area = ACC_BOTTOM;
    else running_area += t;
  endtask

  task automatic fold_in_sample(input bit [14:0] ang, input bit [15:0] dist_in, input bit last);
    bit [15:0]   distance;
    longint      a;
    scan_total_t tot;
    distance = dist_in;
    if (have_prev) begin
      // a dropout repeats the previous range and adds nothing
      if (prev_dist != 0 && distance == 0) distance = prev_dist;
      else add_triangle(prev_dist, distance, int'(ang) - int'(prev_angle));
    end
    prev_angle = ang;
    prev_dist  = distance;
    have_prev  = 1'b1;
    if (samples_in_scan < COUNT_CAP) samples_in_scan++;
    if (last) begin
      a = running_area;
      if (a > AREA_TOP) a = AREA_TOP;
      if (a < AREA_BOTTOM) a = AREA_BOTTOM;
      tot.area  = a[psaa_pkg::AREA_W-1:0];
      tot.count = samples_in_scan;
      scan_totals_q.push_back(tot);
      clear_scan();
    end
  endtask

  task automatic check_total();
    scan_total_t want;
    if (scan_totals_q.size() == 0) begin
      report_mismatch($sformatf("scan total with none pending: area %0d count %0d",
                                area, sample_count));
    end else begin
      want = scan_totals_q.pop_front();
      if (area !== want.area)
        report_mismatch($sformatf("area %0d, predicted %0d", area, $signed(want.area)));
      if (sample_count !== want.count)
        report_mismatch($sformatf("sample_count %0d, predicted %0d", sample_count, want.count));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_scan();
      scan_totals_q.delete();
    end else begin
      // compare first: a total never leaves in the cycle its last sample enters
      if (result_valid && !result_stall) check_total();
      if (sample_valid && !sample_stall)
        fold_in_sample({angle_high, angle_low[7:1]}, {distance_high, distance_low}, last_sample);
    end
    totals_waiting = scan_totals_q.size();
  end

endmodule

/* bench/polar_scan_area_accumulator_test.sv */
`timescale 1ns / 1ps
// Top of the polar_scan_area_accumulator bench: clock, reset, sample stimulus and verdict.
// Depends on the RTL, psaa_pkg and psaa_scan_checker, which does all the predicting and comparing.
module polar_scan_area_accumulator_test;

  localparam int SINE_FRAC_BITS = 16;
  localparam int AREA_FRAC_BITS = 8;
  localparam int QUARTER_TURN = 5760;
  localparam int HALF_TURN    = 11520;
  localparam int DRAIN_CYCLES = 60;
  localparam int SATURATING_SCAN_LEN = 1050;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       sample_valid = 1'b0;
  logic       sample_stall;
  logic [7:0] angle_high = '0;
  logic [7:0] angle_low = '0;
  logic [7:0] distance_high = '0;
  logic [7:0] distance_low = '0;
  logic       last_sample = 1'b0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic signed [psaa_pkg::AREA_W-1:0] area;
  logic [psaa_pkg::COUNT_W-1:0]       sample_count;

  int mismatch_count;
  int totals_waiting;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int rx_hold = 0;

  always #2 clk = ~clk;

  polar_scan_area_accumulator #(
    .SINE_FRAC_BITS(SINE_FRAC_BITS),
    .AREA_FRAC_BITS(AREA_FRAC_BITS)
  ) dut (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall),
    .angle_high(angle_high), .angle_low(angle_low),
    .distance_high(distance_high), .distance_low(distance_low),
    .last_sample(last_sample),
    .result_valid(result_valid), .result_stall(result_stall),
    .area(area), .sample_count(sample_count)
  );

  psaa_scan_checker #(
    .SINE_FRAC_BITS(SINE_FRAC_BITS),
    .AREA_FRAC_BITS(AREA_FRAC_BITS)
  ) checker_i (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall),
    .angle_high(angle_high), .angle_low(angle_low),
    .distance_high(distance_high), .distance_low(distance_low),
    .last_sample(last_sample),
    .result_valid(result_valid), .result_stall(result_stall),
    .area(area), .sample_count(sample_count),
    .mismatch_count(mismatch_count), .totals_waiting(totals_waiting)
  );

  // Receiver stalls in random bursts, started only while rx_idle is set
  always @(negedge clk) begin
    if (rx_hold != 0) begin
      result_stall <= 1'b1;
      rx_hold--;
    end else if (rx_idle && $urandom_range(0, 9) == 0) begin
      result_stall <= 1'b1;
      rx_hold = $urandom_range(0, 6);
    end else begin
      result_stall <= 1'b0;
    end
  end

  task automatic send_sample(input bit [14:0] ang, input bit [15:0] distance, input bit last,
                             input bit spare);
    @(negedge clk);
    if (tx_idle && $urandom_range(0, 7) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    sample_valid  <= 1'b1;
    angle_high    <= ang[14:7];
    angle_low     <= {ang[6:0], spare};
    distance_high <= distance[15:8];
    distance_low  <= distance[7:0];
    last_sample   <= last;
    do @(posedge clk); while (sample_stall);
  endtask

  task automatic drain_totals();
    @(negedge clk);
    sample_valid <= 1'b0;
    while (totals_waiting != 0) @(negedge clk);
  endtask

  // Scans of random length; angles mostly sweep forward like a real scanner
  task automatic random_scans(input int n_items);
    int        left;
    int        len;
    int        pick;
    bit [14:0] ang;
    bit [15:0] distance;
    left = n_items;
    while (left > 0) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
      if (len > left) len = left;
      ang = 15'($urandom);
      for (int i = 0; i < len; i++) begin
        pick = $urandom_range(0, 19);
        if (pick < 14) ang = ang + 15'($urandom_range(0, 400));
        else if (pick < 17) ang = ang - 15'($urandom_range(0, 400));
        else ang = 15'($urandom);
        pick = $urandom_range(0, 9);
        if (pick < 2) distance = '0;
        else if (pick == 2) distance = 16'hFFFF;
        else if (pick == 3) distance = 16'($urandom_range(1, 255));
        else distance = 16'($urandom);
        send_sample(ang, distance, i == len - 1, 1'($urandom_range(0, 1)));
      end
      left -= len;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // full range at a right angle, dropouts, angle wrap past 360 degrees
    send_sample(15'd0, 16'hFFFF, 1'b0, 1'b0);
    send_sample(15'(QUARTER_TURN), 16'hFFFF, 1'b0, 1'b1);
    send_sample(15'(QUARTER_TURN), 16'h0000, 1'b0, 1'b0);
    send_sample(15'(HALF_TURN), 16'h0000, 1'b0, 1'b1);
    send_sample(15'h7FFF, 16'h0001, 1'b0, 1'b0);
    send_sample(15'd0, 16'hFFFF, 1'b0, 1'b1);
    send_sample(15'(HALF_TURN), 16'hFFFF, 1'b1, 1'b0);
    // single-sample scan
    send_sample(15'd100, 16'd1234, 1'b1, 1'b1);
    // clockwise sweep gives a negative area
    send_sample(15'(QUARTER_TURN), 16'hFFFF, 1'b0, 1'b0);
    send_sample(15'd0, 16'hFFFF, 1'b0, 1'b0);
    send_sample(15'(3 * QUARTER_TURN), 16'hFFFF, 1'b0, 1'b1);
    send_sample(15'(HALF_TURN + 1), 16'h8000, 1'b0, 1'b0);
    send_sample(15'(HALF_TURN - 1), 16'h00FF, 1'b1, 1'b1);
    // zero ranges from the start: nothing to repeat
    send_sample(15'd0, 16'h0000, 1'b0, 1'b0);
    send_sample(15'd100, 16'h0000, 1'b0, 1'b1);
    send_sample(15'd200, 16'h00FF, 1'b0, 1'b0);
    send_sample(15'h4000, 16'h5555, 1'b0, 1'b1);
    send_sample(15'h3FFF, 16'hAAAA, 1'b0, 1'b0);
    send_sample(15'd300, 16'h0001, 1'b1, 1'b0);
    // zero after nonzero as the last sample
    send_sample(15'd1, 16'h7FFF, 1'b0, 1'b1);
    send_sample(15'd2, 16'h0000, 1'b1, 1'b0);

    // hold off until every pending total is out
    drain_totals();

    random_scans(500);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    random_scans(100);

    // right-angle steps at full range drive the sample count into saturation
    for (int i = 0; i < SATURATING_SCAN_LEN; i++)
      send_sample(15'((i % 4) * QUARTER_TURN), 16'hFFFF, i == SATURATING_SCAN_LEN - 1,
                  i[0]);

    random_scans(50);

    drain_totals();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #25000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
